>>> rtl/core/pvd_pkg.sv
// Shared types, constants and helper functions for the prefix varint decoder.
`timescale 1ns / 1ps

package pvd_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 4;

  // One decoded value and the byte count of its encoding.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   byte_length;
  } pvd_result_t;

  // Count the run of one bits from the top of a first byte (0..8).
  function automatic logic [LenW-1:0] lead_ones(input logic [ByteW-1:0] b);
    logic [LenW-1:0] cnt;
    logic            run;
    cnt = '0;
    run = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      run = run & b[i];
      if (run) begin
        cnt = cnt + LenW'(1);
      end
    end
    return cnt;
  endfunction

  // Undo sign folding in signed mode: odd raw gives ~(raw >> 1), even gives raw >> 1; else raw passes.
  function automatic logic [ValueW-1:0] unfold_sign(input logic [ValueW-1:0] raw,
                                                     input logic            signed_mode);
    logic [ValueW-1:0] half;
    half = raw >> 1;
    if (!signed_mode) begin
      return raw;
    end
    return raw[0] ? ~half : half;
  endfunction

endpackage

>>> rtl/core/pvd_decode.sv
// Byte-at-a-time decode stage: prefix length detect, value shift-in, sign unfold.
`timescale 1ns / 1ps

module pvd_decode
  import pvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_in,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              signed_mode,
  output logic              res_valid,
  output pvd_result_t       res
);

  logic [LenW-1:0]   bytes_left_r, bytes_left_nxt;
  logic [LenW-1:0]   total_len_r, total_len_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;

  logic [LenW-1:0]   lead_cnt;
  logic [ByteW-1:0]  first_rest;
  logic [ValueW-1:0] shifted;

  // Split a first byte into its length prefix and its value bits
  assign lead_cnt   = lead_ones(data_byte);
  assign first_rest = data_byte & (8'hFF >> lead_cnt);
  assign shifted    = {acc_r[ValueW-ByteW-1:0], data_byte};

  // Advance the decode state and produce a result on the last byte
  always_comb begin
    bytes_left_nxt  = bytes_left_r;
    total_len_nxt   = total_len_r;
    acc_nxt         = acc_r;
    res_valid       = 1'b0;
    res.value       = '0;
    res.byte_length = '0;
    if (beat_in) begin
      if (bytes_left_r == '0) begin
        if (lead_cnt == '0) begin
          res_valid       = 1'b1;
          res.value       = unfold_sign(ValueW'(first_rest), signed_mode);
          res.byte_length = LenW'(1);
        end else begin
          acc_nxt        = ValueW'(first_rest);
          bytes_left_nxt = lead_cnt;
          total_len_nxt  = lead_cnt + LenW'(1);
        end
      end else begin
        acc_nxt        = shifted;
        bytes_left_nxt = bytes_left_r - LenW'(1);
        if (bytes_left_r == LenW'(1)) begin
          res_valid       = 1'b1;
          res.value       = unfold_sign(shifted, signed_mode);
          res.byte_length = total_len_r;
        end
      end
    end
  end

  // Hold control state under reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_len_r <= total_len_nxt;
    acc_r       <= acc_nxt;
  end

endmodule

>>> rtl/core/pvd_outreg.sv
// Result register that holds a decoded beat until the receiver takes it.
`timescale 1ns / 1ps

module pvd_outreg
  import pvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  pvd_result_t res,
  input  logic        out_stall,
  output logic        out_valid,
  output pvd_result_t out_res,
  output logic        full_blocked
);

  logic        valid_r, valid_nxt;
  pvd_result_t res_r;

  // Blocked only while a result sits here and the receiver stalls
  assign full_blocked = valid_r & out_stall;
  assign valid_nxt    = res_valid | full_blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a new beat; otherwise hold
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/core/prefix_varint_decoder.sv
// Top level of the prefix-length 64-bit varint decoder.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel: one message byte per beat on in_data_byte, with in_valid
//   and in_stall. A first byte's leading ones give 0..8 continuation bytes.
//   Result channel: out_value (64 bits) and out_byte_length (1..9) with
//   out_valid and out_stall, one beat per completed encoding.
//   Configuration: cfg_we writes cfg_signed_mode (1 = undo sign folding);
//   write it only while no encoding is in progress.
//   Throughput: one byte per cycle while in_stall is low. Decode is a
//   single combinational pass from the accepted byte and the accumulator
//   into the result register, which loads as the last byte of an encoding
//   is accepted; the result appears in the cycle after.
//   Stall: a result waits in the result register; input bytes keep flowing
//   until that register is full and stalled, then in_stall rises.
//   Reset: rst_n (synchronous, active low) drops any partial encoding,
//   empties the result register and clears signed mode.
//
module prefix_varint_decoder
  import pvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ByteW-1:0]  in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ValueW-1:0] out_value,
  output logic [LenW-1:0]   out_byte_length,
  input  logic              cfg_we,
  input  logic              cfg_signed_mode
);

  logic        signed_mode_r;
  logic        beat_in;
  logic        res_valid;
  pvd_result_t res;
  pvd_result_t out_res;
  logic        full_blocked;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      signed_mode_r <= cfg_signed_mode;
    end
  end

  assign in_stall = full_blocked;
  assign beat_in  = in_valid & ~full_blocked;

  pvd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat_in     (beat_in),
    .data_byte   (in_data_byte),
    .signed_mode (signed_mode_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  pvd_outreg u_outreg (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res          (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .full_blocked (full_blocked)
  );

  assign out_value       = out_res.value;
  assign out_byte_length = out_res.byte_length;

endmodule

>>> sim/tb_prefix_varint_decoder.sv
// Self-checking testbench for the prefix-length 64-bit varint decoder.
`timescale 1ns / 1ps

module tb_prefix_varint_decoder;
  import pvd_pkg::*;

  localparam int unsigned PressureCycles = 300;
  localparam int unsigned PhaseBytes     = 270;
  localparam int unsigned NumPhases      = 5;

  // Decode predictor: tracks the encoding in progress and queues decoded values.
  class varint_scoreboard;
    logic              signed_mode;
    logic [LenW-1:0]   left;
    logic [LenW-1:0]   total;
    logic [ValueW-1:0] acc;
    pvd_result_t       decoded_q[$];
    int                errors;
    int                checked;

    function new();
      signed_mode = 1'b0;
      left        = '0;
      total       = '0;
      acc         = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endfunction

    // Undo sign folding from the low bit when signed mode is set.
    function logic [ValueW-1:0] apply_sign(logic [ValueW-1:0] raw);
      if (!signed_mode) begin
        return raw;
      end
      return raw[0] ? ~(raw >> 1) : (raw >> 1);
    endfunction

    function void push_value(logic [ValueW-1:0] raw, logic [LenW-1:0] len);
      pvd_result_t r;
      r.value       = apply_sign(raw);
      r.byte_length = len;
      decoded_q.push_back(r);
    endfunction

    // Advance the decode by one accepted input beat.
    function void note_byte(logic [ByteW-1:0] b);
      logic [ByteW-1:0] rest;
      logic [LenW-1:0]  ones;
      logic             run;
      if (left == 0) begin
        rest = b;
        ones = '0;
        run  = 1'b1;
        for (int i = ByteW - 1; i >= 0; i--) begin
          run = run & rest[i];
          if (run) begin
            rest[i] = 1'b0;
            ones++;
          end
        end
        if (ones == 0) begin
          push_value(ValueW'(rest), LenW'(1));
        end else begin
          acc   = ValueW'(rest);
          left  = ones;
          total = ones + LenW'(1);
        end
      end else begin
        acc  = {acc[ValueW-ByteW-1:0], b};
        left = left - LenW'(1);
        if (left == 0) begin
          push_value(acc, total);
          acc   = '0;
          total = '0;
        end
      end
    endfunction

    // Compare one accepted result beat against the oldest decoded value.
    function void check_result(logic [ValueW-1:0] v, logic [LenW-1:0] len);
      pvd_result_t e;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h len=%0d", v, len));
        return;
      end
      e = decoded_q.pop_front();
      checked++;
      if (v !== e.value) begin
        report_mismatch($sformatf("value %h, want %h", v, e.value));
      end
      if (len !== e.byte_length) begin
        report_mismatch($sformatf("byte_length %0d, want %0d", len, e.byte_length));
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [ByteW-1:0]  in_data_byte;
  logic              out_valid;
  logic              out_stall;
  logic [ValueW-1:0] out_value;
  logic [LenW-1:0]   out_byte_length;
  logic              cfg_we;
  logic              cfg_signed_mode;

  varint_scoreboard sb;
  int               bytes_sent;
  bit               idle_on;
  bit               stall_on;
  bit               pressure_req;
  bit               saw_in_stall;

  prefix_varint_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_byte_length (out_byte_length),
    .cfg_we          (cfg_we),
    .cfg_signed_mode (cfg_signed_mode)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Send one byte beat, with an optional idle burst first; return once accepted.
  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do begin
      @(posedge clk);
      if (in_stall) begin
        saw_in_stall = 1'b1;
      end
    end while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Send a whole encoding with n continuation bytes carrying the given payload.
  task automatic send_encoding(input int n, input logic [ValueW-1:0] payload);
    logic [ByteW-1:0] first;
    first = ~(8'hFF >> n) | (ByteW'(payload >> (8 * n)) & (8'h7F >> n));
    send_byte(first);
    for (int i = n - 1; i >= 0; i--) begin
      send_byte(payload[8*i +: 8]);
    end
  endtask

  // Feed random bytes until no encoding is left open.
  task automatic close_encoding();
    while (sb.left != 0) begin
      send_byte(ByteW'($urandom));
    end
  endtask

  // Drop valid and wait until every decoded value has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_we          <= 1'b1;
    cfg_signed_mode <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.signed_mode = m;
  endtask

  function automatic logic [ValueW-1:0] random_payload();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly whole encodings with random content, some raw noise bytes.
  task automatic random_phase(input int unsigned nbytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom));
      end else begin
        close_encoding();
        send_encoding($urandom_range(0, 8), random_payload());
      end
    end
    close_encoding();
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_stall <= 1'b1;
        repeat (PressureCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_value, out_byte_length);
    end
  end

  // Main sequence.
  initial begin
    sb              = new();
    bytes_sent      = 0;
    idle_on         = 1'b1;
    stall_on        = 1'b1;
    pressure_req    = 1'b0;
    saw_in_stall    = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    cfg_we          = 1'b0;
    cfg_signed_mode = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    write_mode(1'b0);
    // Unsigned corners: single-byte extremes, 0xFE and 0xFF leads.
    send_byte(8'h00);
    send_byte(8'h7F);
    send_encoding(7, 64'h00AB_CDEF_0123_4567);
    send_encoding(8, '0);

    write_mode(1'b1);
    // Signed corners: odd and even single bytes, all-ones 64-bit value.
    send_byte(8'h7F);
    send_byte(8'h7E);
    send_encoding(8, '1);

    for (int p = 0; p < NumPhases; p++) begin
      write_mode(p[0]);
      if (p == NumPhases - 1) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      if (p == 1) begin
        pressure_req = 1'b1;
      end
      random_phase(PhaseBytes);
    end

    drain();
    $display("Run covered %0d input bytes and %0d decoded values in both sign modes,",
             bytes_sent, sb.checked);
    $display("with a long output hold-off (input stall seen: %0d).", saw_in_stall);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("Timeout waiting for the decoder");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
